### rtl/core/range_add_range_maxmin_tree_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef RANGE_ADD_RANGE_MAXMIN_TREE_UNIT_MACROS_SVH
`define RANGE_ADD_RANGE_MAXMIN_TREE_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define RARM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define RARM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/rarm_pkg.sv
package rarm_pkg;

	localparam int LEAVES_DEF      = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic signed [31:0] EMPTY_MAX = -32'sd1000000000;
	localparam logic signed [31:0] EMPTY_MIN = 32'sd1000000000;

endpackage

### rtl/core/rarm_ram.sv
module rarm_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### rtl/core/rarm_seq.sv
module rarm_seq #(
	parameter int LEAVES      = rarm_pkg::LEAVES_DEF,
	parameter int VALUE_WIDTH = rarm_pkg::VALUE_WIDTH_DEF,
	localparam int NODES = 4 * LEAVES,
	localparam int AW    = $clog2(NODES),
	localparam int VW    = VALUE_WIDTH,
	localparam int DW    = 3 * VW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                in_mode,
	input  logic [10:0]         in_start,
	input  logic [10:0]         in_end,
	input  logic signed [15:0]  in_value,
	output logic                ready,
	input  logic                res_free,
	output logic                res_valid,
	output logic signed [31:0]  res_hi,
	output logic signed [31:0]  res_lo,
	output logic                ram_we,
	output logic [AW-1:0]       ram_addr,
	output logic [DW-1:0]       ram_wdata,
	input  logic [DW-1:0]       ram_rdata
);

	localparam int LW  = $clog2(LEAVES + 1);
	localparam int IW  = (LW > 11) ? LW : 11;
	localparam int CW  = (VW > 32) ? VW : 32;
	localparam int AXW = (VW > 16) ? VW : 16;
	localparam int SD  = $clog2(LEAVES) + 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = $clog2(SD);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_C0RD = 4'd4;
	localparam logic [3:0] ST_C0WR = 4'd5;
	localparam logic [3:0] ST_C1RD = 4'd6;
	localparam logic [3:0] ST_C1WR = 4'd7;
	localparam logic [3:0] ST_DEC  = 4'd8;
	localparam logic [3:0] ST_RET  = 4'd9;

	logic [3:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic                  mode_q;
	logic [IW-1:0]         s_q;
	logic [IW-1:0]         e_q;
	logic signed [VW-1:0]  x_q;
	logic [AW-1:0]         cur_k_q;
	logic [LW-1:0]         cur_l_q;
	logic [LW-1:0]         cur_r_q;
	logic signed [VW-1:0]  cmax_q;
	logic signed [VW-1:0]  cmin_q;
	logic signed [VW-1:0]  p_q;
	logic signed [CW-1:0]  res_hi_q;
	logic signed [CW-1:0]  res_lo_q;
	logic [SPW-1:0]        sp_q;

	logic [AW-1:0]         stk_k_q   [SD];
	logic [LW-1:0]         stk_l_q   [SD];
	logic [LW-1:0]         stk_r_q   [SD];
	logic                  stk_ph_q  [SD];
	logic signed [CW-1:0]  stk_ahi_q [SD];
	logic signed [CW-1:0]  stk_alo_q [SD];

	logic signed [VW-1:0]  d_max, d_min, d_p;
	logic [LW:0]           cur_sum, top_sum;
	logic [LW-1:0]         cur_mid, top_mid;
	logic [IW-1:0]         l_x, r_x;
	logic                  disjoint, full, internal;
	logic [SPW-1:0]        top_p;
	logic [SIW-1:0]        top_i, push_i;
	logic signed [CW-1:0]  cmb_hi, cmb_lo;
	logic [AW-1:0]         child0;

	assign d_max    = ram_rdata[VW-1:0];
	assign d_min    = ram_rdata[2*VW-1:VW];
	assign d_p      = ram_rdata[DW-1:2*VW];
	assign cur_sum  = {1'b0, cur_l_q} + {1'b0, cur_r_q};
	assign cur_mid  = cur_sum[LW:1];
	assign l_x      = IW'(cur_l_q);
	assign r_x      = IW'(cur_r_q);
	assign disjoint = (r_x <= s_q) || (e_q <= l_x);
	assign full     = (s_q <= l_x) && (r_x <= e_q);
	assign internal = (cur_r_q - cur_l_q) > LW'(1);
	assign child0   = {cur_k_q[AW-2:0], 1'b0};
	assign top_p    = sp_q - SPW'(1);
	assign top_i    = top_p[SIW-1:0];
	assign push_i   = sp_q[SIW-1:0];
	assign top_sum  = {1'b0, stk_l_q[top_i]} + {1'b0, stk_r_q[top_i]};
	assign top_mid  = top_sum[LW:1];
	assign cmb_hi   = (stk_ahi_q[top_i] > res_hi_q) ? stk_ahi_q[top_i] : res_hi_q;
	assign cmb_lo   = (stk_alo_q[top_i] < res_lo_q) ? stk_alo_q[top_i] : res_lo_q;

	assign ready     = (state_q == ST_IDLE);
	assign res_hi    = res_hi_q[31:0];
	assign res_lo    = res_lo_q[31:0];
	assign res_valid = (state_q == ST_RET) && (sp_q == '0)
		&& (mode_q == rarm_pkg::MODE_QUERY) && res_free;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cur_k_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_CHK: begin
				// apply the pending add to this node, clear it
				ram_we    = 1'b1;
				ram_wdata = {VW'(0), VW'(d_min + d_p), VW'(d_max + d_p)};
			end
			ST_C0RD: ram_addr = child0;
			ST_C0WR: begin
				ram_we    = 1'b1;
				ram_addr  = child0;
				ram_wdata = {VW'(d_p + p_q), d_min, d_max};
			end
			ST_C1RD: ram_addr = child0 | AW'(1);
			ST_C1WR: begin
				ram_we    = 1'b1;
				ram_addr  = child0 | AW'(1);
				ram_wdata = {VW'(d_p + p_q), d_min, d_max};
			end
			ST_DEC: begin
				if (!disjoint && full && mode_q == rarm_pkg::MODE_ADD) begin
					ram_we    = 1'b1;
					ram_wdata = {x_q, cmin_q, cmax_q};
				end
			end
			ST_RET: begin
				if (sp_q != '0 && stk_ph_q[top_i] && mode_q == rarm_pkg::MODE_ADD) begin
					ram_we    = 1'b1;
					ram_addr  = stk_k_q[top_i];
					ram_wdata = {VW'(0), cmb_lo[VW-1:0], cmb_hi[VW-1:0]};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			sp_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						sp_q    <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:   state_q <= ST_CHK;
				ST_CHK:  state_q <= (d_p != '0 && internal) ? ST_C0RD : ST_DEC;
				ST_C0RD: state_q <= ST_C0WR;
				ST_C0WR: state_q <= ST_C1RD;
				ST_C1RD: state_q <= ST_C1WR;
				ST_C1WR: state_q <= ST_DEC;
				ST_DEC: begin
					if (disjoint || full) begin
						state_q <= ST_RET;
					end else begin
						sp_q    <= sp_q + SPW'(1);
						state_q <= ST_RD;
					end
				end
				ST_RET: begin
					if (sp_q == '0) begin
						if (mode_q == rarm_pkg::MODE_ADD || res_free) begin
							state_q <= ST_IDLE;
						end
					end else if (!stk_ph_q[top_i]) begin
						state_q <= ST_RD;
					end else begin
						sp_q <= top_p;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and frame stack, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q  <= in_mode;
				s_q     <= IW'(in_start);
				e_q     <= IW'(in_end);
				x_q     <= VW'(AXW'(in_value));
				cur_k_q <= AW'(1);
				cur_l_q <= '0;
				cur_r_q <= LW'(LEAVES);
			end
			ST_CHK: begin
				cmax_q <= d_max + d_p;
				cmin_q <= d_min + d_p;
				p_q    <= d_p;
			end
			ST_DEC: begin
				if (disjoint) begin
					if (mode_q == rarm_pkg::MODE_ADD) begin
						res_hi_q <= CW'(cmax_q);
						res_lo_q <= CW'(cmin_q);
					end else begin
						res_hi_q <= CW'(rarm_pkg::EMPTY_MAX);
						res_lo_q <= CW'(rarm_pkg::EMPTY_MIN);
					end
				end else if (full) begin
					if (mode_q == rarm_pkg::MODE_ADD) begin
						res_hi_q <= CW'(VW'(cmax_q + x_q));
						res_lo_q <= CW'(VW'(cmin_q + x_q));
					end else begin
						res_hi_q <= CW'(cmax_q);
						res_lo_q <= CW'(cmin_q);
					end
				end else begin
					// descend left, remember this node
					stk_k_q[push_i]  <= cur_k_q;
					stk_l_q[push_i]  <= cur_l_q;
					stk_r_q[push_i]  <= cur_r_q;
					stk_ph_q[push_i] <= 1'b0;
					cur_k_q          <= child0;
					cur_r_q          <= cur_mid;
				end
			end
			ST_RET: begin
				if (sp_q != '0) begin
					if (!stk_ph_q[top_i]) begin
						stk_ph_q[top_i]  <= 1'b1;
						stk_ahi_q[top_i] <= res_hi_q;
						stk_alo_q[top_i] <= res_lo_q;
						cur_k_q          <= {stk_k_q[top_i][AW-2:0], 1'b1};
						cur_l_q          <= top_mid;
						cur_r_q          <= stk_r_q[top_i];
					end else begin
						res_hi_q <= cmb_hi;
						res_lo_q <= cmb_lo;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/range_add_range_maxmin_tree_unit.sv
// Channel | Direction | Beat contents
// input   | in        | mode, range_start, range_end, add_value (in_valid / in_ready)
// output  | out       | range_max, range_min, one beat per query (out_valid / out_ready)
//
// Each visited tree node is read, checked and decided on the single tree memory port,
// with a read and a write of each child when a pending add moves down to them; each
// node that splits is revisited on the way back up, and a final return step finishes
// the item. in_ready stays low from the accepted item until it is finished.
// After reset a clearing pass writes all 4*LEAVES nodes, one per cycle, before in_ready rises.
// One item is worked at a time; a finished query waits only while out is stalled.
module range_add_range_maxmin_tree_unit #(
	parameter int LEAVES      = rarm_pkg::LEAVES_DEF,
	parameter int VALUE_WIDTH = rarm_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [10:0]        range_start,
	input  logic [10:0]        range_end,
	input  logic signed [15:0] add_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] range_max,
	output logic signed [31:0] range_min
);

	localparam int NODES = 4 * LEAVES;
	localparam int AW    = $clog2(NODES);
	localparam int DW    = 3 * VALUE_WIDTH;

	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [DW-1:0]      ram_wdata;
	logic [DW-1:0]      ram_rdata;
	logic               seq_ready;
	logic               res_valid;
	logic               res_free;
	logic signed [31:0] res_hi;
	logic signed [31:0] res_lo;
	logic               out_valid_q;
	logic signed [31:0] range_max_q;
	logic signed [31:0] range_min_q;

	assign in_ready  = seq_ready;
	assign res_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign range_max = range_max_q;
	assign range_min = range_min_q;

	rarm_ram #(
		.WIDTH(DW),
		.DEPTH(NODES)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	rarm_seq #(
		.LEAVES      (LEAVES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && seq_ready),
		.in_mode   (mode),
		.in_start  (range_start),
		.in_end    (range_end),
		.in_value  (add_value),
		.ready     (seq_ready),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res_hi    (res_hi),
		.res_lo    (res_lo),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			range_max_q <= res_hi;
			range_min_q <= res_lo;
		end
	end

endmodule

### rtl/core/rarm_checker.sv
`include "range_add_range_maxmin_tree_unit_macros.svh"

module rarm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	`RARM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out dropped")
	`RARM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "taken busy")
	`RARM_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "early")
	`RARM_ASSERT_NEXT(a_idle_hold_ready, clk, arst_n, in_ready && !in_valid, in_ready, "ready lost")

endmodule

bind range_add_range_maxmin_tree_unit rarm_checker u_rarm_checker (.*);
